[rtl/skvt_pkg.sv]
// Shared types and codes of the sorted key/value table.
package skvt_pkg;

	typedef logic signed [31:0] key_t;
	typedef logic [31:0] value_t;

	typedef struct packed {
		key_t key;
		value_t value;
	} entry_t;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_DEL_KEY = 3'd1,
		OP_DEL_IDX = 3'd2,
		OP_FIND    = 3'd3,
		OP_READ    = 3'd4,
		OP_COUNT   = 3'd5,
		OP_CLEAR   = 3'd6,
		OP_NOP     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT,
		CELL_LOAD
	} cell_mode_t;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} row_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SEARCH,
		S_READ,
		S_READ2,
		S_OUT,
		S_INSERT
	} state_t;

endpackage

[rtl/skvt_cell.sv]
// One table cell: holds an entry, compares it with the search key, shifts.
module skvt_cell (
	input  logic                    clk,
	input  skvt_pkg::cell_mode_t    mode,
	input  skvt_pkg::entry_t        prev_entry,
	input  skvt_pkg::entry_t        next_entry,
	input  skvt_pkg::entry_t        new_entry,
	input  skvt_pkg::key_t          search_key,
	output skvt_pkg::entry_t        entry,
	output logic                    lt,
	output logic                    eq
);
	import skvt_pkg::*;

	entry_t entry_q;
	logic   lt_q;
	logic   eq_q;

	always_ff @(posedge clk) begin
		unique case (mode)
			CELL_HOLD:      entry_q <= entry_q;
			CELL_FROM_PREV: entry_q <= prev_entry;
			CELL_FROM_NEXT: entry_q <= next_entry;
			CELL_LOAD:      entry_q <= new_entry;
			default:        entry_q <= entry_q;
		endcase
	end

	// Flags are registered from the held key and the search key.
	always_ff @(posedge clk) begin
		lt_q <= $signed(entry_q.key) < $signed(search_key);
		eq_q <= entry_q.key == search_key;
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

[rtl/skvt_row.sv]
// Row of cells with shift steering and a registered read-out tree.
module skvt_row #(
	parameter int CAPACITY = 256
) (
	input  logic                            clk,
	input  skvt_pkg::row_ctrl_t             ctrl,
	input  logic [$clog2(CAPACITY)-1:0]     pos,
	input  skvt_pkg::entry_t                new_entry,
	input  skvt_pkg::key_t                  search_key,
	output logic [CAPACITY-1:0]             eq_vec,
	output logic [CAPACITY-1:0]             lt_vec,
	output skvt_pkg::entry_t                rd_entry
);
	import skvt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int G  = 16;
	localparam int NG = (CAPACITY + G - 1) / G;

	entry_t entries [CAPACITY];
	entry_t pad     [NG*G];
	entry_t grp_c   [NG];
	entry_t grp_s1  [NG];
	entry_t rd_c;
	entry_t rd_s2;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [IW-1:0] POS = IW'(i);
		cell_mode_t mode;
		entry_t     prev_e;
		entry_t     next_e;

		if (i == 0) begin : g_first
			assign prev_e = entries[i];
		end else begin : g_mid
			assign prev_e = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = entries[i];
		end else begin : g_inner
			assign next_e = entries[i+1];
		end

		always_comb begin
			mode = CELL_HOLD;
			priority if (ctrl.shift_up) begin
				if (POS > pos)
					mode = CELL_FROM_PREV;
				else if (POS == pos)
					mode = CELL_LOAD;
			end else if (ctrl.shift_down) begin
				if (POS >= pos)
					mode = CELL_FROM_NEXT;
			end else begin
				mode = CELL_HOLD;
			end
		end

		skvt_cell u_cell (
			.clk        (clk),
			.mode       (mode),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.new_entry  (new_entry),
			.search_key (search_key),
			.entry      (entries[i]),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	for (genvar p = 0; p < NG*G; p++) begin : g_pad
		if (p < CAPACITY) begin : g_real
			assign pad[p] = entries[p];
		end else begin : g_zero
			assign pad[p] = '0;
		end
	end

	// First level: one selected entry per group of sixteen cells.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_c[g] = '0;
			for (int j = 0; j < G; j++) begin
				if (int'(pos) == g*G + j)
					grp_c[g] = grp_c[g] | pad[g*G + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_c;
	end

	always_comb begin
		rd_c = '0;
		for (int g = 0; g < NG; g++)
			rd_c = rd_c | grp_s1[g];
	end

	always_ff @(posedge clk) begin
		rd_s2 <= rd_c;
	end

	assign rd_entry = rd_s2;

endmodule

[rtl/sorted_key_value_table_top.sv]
// Sorted key/value table: sequencer over a row of shifting cells.
//
// Usage: drive operation, key, value and index and raise start while busy is
// low; that edge takes the transaction. busy stays high until the result is
// issued. done is high for exactly one cycle with status, found, key_out,
// value_out and count; the receiver cannot stall, so the result must be taken
// in that cycle. A new transaction may start in the cycle done is high.
// Count, clear, no-op and the empty, full and range cases finish in the
// compare state. A key search then runs a binary search over the registered
// compare flags and notices a miss when its bounds meet. A read-out of an
// entry (find, delete, read by index) passes S_READ, S_READ2 and S_OUT for
// the two-stage read tree; an insert shifts the row in S_INSERT.
// The user writes allow_duplicates via cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce it. Reset clears the entry count, the
// duplicate flag and the sequencer; stored entries are undefined until written.
module sorted_key_value_table_top #(
	parameter int CAPACITY = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          operation,
	input  skvt_pkg::key_t      key,
	input  skvt_pkg::value_t    value,
	input  logic [7:0]          index,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output logic                done,
	output logic [2:0]          status,
	output logic                found,
	output skvt_pkg::key_t      key_out,
	output skvt_pkg::value_t    value_out,
	output logic [8:0]          count
);
	import skvt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > 8) ? CW : 8;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            dup_q;
	logic            done_q;

	op_t             op_q;
	key_t            key_q;
	value_t          value_q;
	logic [7:0]      idx_q;
	logic [CW-1:0]   low_q, low_d;
	logic [CW-1:0]   hp1_q, hp1_d;
	logic [IW-1:0]   pos_q, pos_d;
	status_t         status_q, st_res;
	logic            found_q, found_res;
	key_t            kout_q, kout_res;
	value_t          vout_q, vout_res;
	logic [8:0]      cnt_out_q;

	logic            fin;
	row_ctrl_t       row_ctrl;
	logic [CW:0]     mid_sum;
	logic [IW-1:0]   mid;
	logic            empty, full, idx_ok;
	logic [CAPACITY-1:0] eq_vec, lt_vec;
	entry_t          rd_entry;
	entry_t          new_entry;

	assign new_entry = '{key: key_q, value: value_q};

	skvt_row #(.CAPACITY(CAPACITY)) u_row (
		.clk        (clk),
		.ctrl       (row_ctrl),
		.pos        (pos_q),
		.new_entry  (new_entry),
		.search_key (key_q),
		.eq_vec     (eq_vec),
		.lt_vec     (lt_vec),
		.rd_entry   (rd_entry)
	);

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(CAPACITY);
	assign idx_ok  = MW'(idx_q) < MW'(count_q);
	assign mid_sum = {1'b0, low_q} + {1'b0, hp1_q} - (CW+1)'(1);
	assign mid     = mid_sum[IW:1];

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		low_d     = low_q;
		hp1_d     = hp1_q;
		pos_d     = pos_q;
		fin       = 1'b0;
		st_res    = ST_OK;
		found_res = 1'b0;
		kout_res  = '0;
		vout_res  = '0;
		row_ctrl  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_CMP;
			end
			S_CMP: begin
				unique case (op_q)
					OP_INSERT: begin
						if (full) begin
							fin    = 1'b1;
							st_res = ST_FULL;
						end else begin
							state_d = S_SEARCH;
						end
					end
					OP_DEL_KEY, OP_FIND: begin
						if (empty) begin
							fin    = 1'b1;
							st_res = ST_EMPTY;
						end else begin
							state_d = S_SEARCH;
						end
					end
					OP_DEL_IDX, OP_READ: begin
						priority if (op_q == OP_DEL_IDX && empty) begin
							fin    = 1'b1;
							st_res = ST_EMPTY;
						end else if (!idx_ok) begin
							fin    = 1'b1;
							st_res = ST_RANGE;
						end else begin
							pos_d   = IW'(idx_q);
							state_d = S_READ;
						end
					end
					OP_CLEAR: begin
						count_d = '0;
						fin     = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_SEARCH: begin
				if (low_q < hp1_q) begin
					priority if (eq_vec[mid]) begin
						if (op_q == OP_INSERT) begin
							if (dup_q) begin
								pos_d   = mid + IW'(1);
								state_d = S_INSERT;
							end else begin
								fin    = 1'b1;
								st_res = ST_DUP;
							end
						end else begin
							pos_d   = mid;
							state_d = S_READ;
						end
					end else if (lt_vec[mid]) begin
						low_d = CW'(mid) + CW'(1);
					end else begin
						hp1_d = CW'(mid);
					end
				end else begin
					// Miss: an insert lands at the final low bound.
					if (op_q == OP_INSERT) begin
						pos_d   = IW'(low_q);
						state_d = S_INSERT;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_READ: begin
				state_d = S_READ2;
			end
			S_READ2: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				fin       = 1'b1;
				kout_res  = rd_entry.key;
				vout_res  = rd_entry.value;
				found_res = (op_q == OP_DEL_KEY) || (op_q == OP_FIND);
				if ((op_q == OP_DEL_KEY) || (op_q == OP_DEL_IDX)) begin
					row_ctrl.shift_down = 1'b1;
					count_d             = count_q - CW'(1);
				end
			end
			S_INSERT: begin
				fin               = 1'b1;
				row_ctrl.shift_up = 1'b1;
				count_d           = count_q + CW'(1);
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin)
			state_d = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dup_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (cfg_we)
				dup_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= op_t'(operation);
			key_q   <= key;
			value_q <= value;
			idx_q   <= index;
			low_q   <= '0;
			hp1_q   <= count_q;
		end else begin
			low_q <= low_d;
			hp1_q <= hp1_d;
		end
		pos_q <= pos_d;
		if (fin) begin
			status_q  <= st_res;
			found_q   <= found_res;
			kout_q    <= kout_res;
			vout_q    <= vout_res;
			cnt_out_q <= 9'(count_d);
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign status    = status_q;
	assign found     = found_q;
	assign key_out   = kout_q;
	assign value_out = vout_q;
	assign count     = cnt_out_q;

endmodule

[tb/sorted_key_value_table_top_test.sv]
// Self-checking testbench of the sorted key/value table, with its own model of the table.
module sorted_key_value_table_top_test;
	import skvt_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		status_t    status;
		logic       found;
		key_t       key_out;
		value_t     value_out;
		logic [8:0] count;
	} table_result_t;

	// Mirror of the table contents; works out the result of each accepted transaction.
	class sorted_pair_table;
		key_t          keys [TABLE_DEPTH];
		value_t        vals [TABLE_DEPTH];
		int            n;
		bit            dup_ok;
		table_result_t pending_results [$];
		int            failures;
		int            checked;
		int            op_seen [8];
		int            full_hits;
		int            dup_hits;
		int            peak;

		function void place(int pos, key_t k, value_t v);
			for (int i = n; i > pos; i--) begin
				keys[i] = keys[i - 1];
				vals[i] = vals[i - 1];
			end
			keys[pos] = k;
			vals[pos] = v;
			n++;
		endfunction

		function void remove_at(int pos);
			for (int i = pos; i + 1 < n; i++) begin
				keys[i] = keys[i + 1];
				vals[i] = vals[i + 1];
			end
			n--;
		endfunction

		function bit locate(key_t k, output int pos);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = n - 1;
			pos = 0;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (keys[mid] == k) begin
					pos = mid;
					return 1'b1;
				end else if (keys[mid] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return 1'b0;
		endfunction

		function status_t insert_pair(key_t k, value_t v);
			int lo;
			int hi;
			int mid;
			if (n >= TABLE_DEPTH)
				return ST_FULL;
			if (n == 0) begin
				place(0, k, v);
				return ST_OK;
			end
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (k == keys[mid]) begin
					if (!dup_ok)
						return ST_DUP;
					// equal key goes right after the probed entry
					place(mid + 1, k, v);
					return ST_OK;
				end else if (k < keys[mid]) begin
					hi = mid - 1;
					if (lo > hi) begin
						place(mid, k, v);
						return ST_OK;
					end
				end else begin
					lo = mid + 1;
					if (lo > hi) begin
						place(mid + 1, k, v);
						return ST_OK;
					end
				end
			end
			place(n, k, v);
			return ST_OK;
		endfunction

		function void note_command(op_t op, key_t k, value_t v, logic [7:0] idx);
			table_result_t r;
			int pos;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: r.status = insert_pair(k, v);
				OP_DEL_KEY, OP_FIND: begin
					if (n == 0) begin
						r.status = ST_EMPTY;
					end else if (locate(k, pos)) begin
						r.found = 1'b1;
						r.key_out = keys[pos];
						r.value_out = vals[pos];
						if (op == OP_DEL_KEY)
							remove_at(pos);
					end
				end
				OP_DEL_IDX: begin
					if (n == 0) begin
						r.status = ST_EMPTY;
					end else if (int'(idx) >= n) begin
						r.status = ST_RANGE;
					end else begin
						r.key_out = keys[idx];
						r.value_out = vals[idx];
						remove_at(int'(idx));
					end
				end
				OP_READ: begin
					if (int'(idx) >= n) begin
						r.status = ST_RANGE;
					end else begin
						r.key_out = keys[idx];
						r.value_out = vals[idx];
					end
				end
				OP_CLEAR: n = 0;
				default: ;
			endcase
			r.count = n[8:0];
			if (r.status == ST_FULL)
				full_hits++;
			if (r.status == ST_DUP)
				dup_hits++;
			if (n > peak)
				peak = n;
			op_seen[op]++;
			pending_results.push_back(r);
		endfunction

		function void show(string field, logic [63:0] exp_v, logic [63:0] act_v);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
			failures++;
		endfunction

		function void check_result(logic [2:0] st, logic fnd, key_t ko, value_t vo,
				logic [8:0] cnt);
			table_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction outstanding, status %0d count %0d",
					$time, st, cnt);
				failures++;
				return;
			end
			e = pending_results.pop_front();
			checked++;
			if (e.status !== st)
				show("status", e.status, st);
			if (e.found !== fnd)
				show("found", e.found, fnd);
			if (e.key_out !== ko)
				show("key_out", e.key_out, ko);
			if (e.value_out !== vo)
				show("value_out", e.value_out, vo);
			if (e.count !== cnt)
				show("count", e.count, cnt);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] operation = OP_NOP;
	key_t       key = '0;
	value_t     value = '0;
	logic [7:0] index = '0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       busy;
	logic       done;
	logic [2:0] status;
	logic       found;
	key_t       key_out;
	value_t     value_out;
	logic [8:0] count;

	sorted_pair_table tbl;
	int               cycle_count = 0;
	int               gap_pct = 0;
	bit               start_held = 1'b0;

	sorted_key_value_table_top #(.CAPACITY(TABLE_DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.key       (key),
		.value     (value),
		.index     (index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.found     (found),
		.key_out   (key_out),
		.value_out (value_out),
		.count     (count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (done)
			tbl.check_result(status, found, key_out, value_out, count);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL sorted_key_value_table_top");
		$finish;
	end

	task automatic issue(op_t op, key_t k, value_t v, logic [7:0] idx);
		operation <= op;
		key <= k;
		value <= v;
		index <= idx;
		start <= 1'b1;
		start_held = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		tbl.note_command(op, k, v, idx);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			start_held = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain;
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
		while (tbl.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_duplicates(bit on);
		drain();
		cfg_wdata <= on;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl.dup_ok = on;
	endtask

	function automatic key_t pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40 && tbl.n > 0)
			return tbl.keys[$urandom_range(tbl.n - 1)];
		if (r < 75)
			return key_t'(int'($urandom_range(32)) - 16);
		if (r < 85) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return '0;
				default: return '1;
			endcase
		end
		return key_t'($urandom);
	endfunction

	function automatic logic [7:0] pick_index();
		if (tbl.n > 0 && $urandom_range(99) < 75)
			return 8'($urandom_range(tbl.n - 1));
		return 8'($urandom_range(255));
	endfunction

	task automatic random_items(int items, int insert_pct);
		int   r;
		op_t  op;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(99);
			if (r < insert_pct) begin
				op = OP_INSERT;
			end else if (r == 99) begin
				op = OP_CLEAR;
			end else if (r >= 97) begin
				op = OP_NOP;
			end else begin
				case ($urandom_range(4))
					0: op = OP_DEL_KEY;
					1: op = OP_DEL_IDX;
					2: op = OP_FIND;
					3: op = OP_READ;
					default: op = OP_COUNT;
				endcase
			end
			issue(op, pick_key(), $urandom, pick_index());
		end
	endtask

	initial begin
		tbl = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// duplicates off, sender idles now and then
		gap_pct = 15;
		set_duplicates(1'b0);
		issue(OP_COUNT, '0, '0, '0);
		issue(OP_FIND, 32'sd3, '0, '0);
		issue(OP_DEL_KEY, 32'sd3, '0, '0);
		issue(OP_DEL_IDX, '0, '0, '0);
		issue(OP_READ, '0, '0, '0);
		issue(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 8'hff);
		issue(OP_INSERT, 32'sh8000_0000, '0, '0);
		issue(OP_INSERT, '0, 32'h1234_5678, '0);
		issue(OP_INSERT, '0, 32'hdead_beef, '0);
		issue(OP_INSERT, '1, 32'h8000_0001, '0);
		issue(OP_FIND, '0, '0, '0);
		issue(OP_FIND, 32'sd5, '0, '0);
		issue(OP_DEL_KEY, 32'sd5, '0, '0);
		issue(OP_READ, '0, '0, '0);
		issue(OP_READ, '0, '0, 8'd3);
		issue(OP_READ, '0, '0, 8'd255);
		issue(OP_DEL_IDX, '0, '0, 8'd200);
		issue(OP_DEL_IDX, '0, '0, 8'd1);
		issue(OP_DEL_KEY, 32'sh7fff_ffff, '0, '0);
		issue(OP_NOP, 32'sh5555_5555, 32'haaaa_aaaa, 8'h55);
		issue(OP_CLEAR, '0, '0, '0);
		issue(OP_COUNT, '0, '0, '0);
		issue(OP_INSERT, 32'sd7, 32'h0000_0007, '0);
		issue(OP_FIND, 32'sd7, '0, '0);
		random_items(300, 50);

		// duplicates on, heavy idling: fill past capacity, then churn
		gap_pct = 51;
		set_duplicates(1'b1);
		issue(OP_INSERT, 32'sd7, 32'h0000_0008, '0);
		issue(OP_INSERT, 32'sd7, 32'h0000_0009, '0);
		for (int i = 0; i < 280; i++)
			issue(OP_INSERT, pick_key(), $urandom, pick_index());
		random_items(200, 35);

		// duplicates off again with equal keys still stored, no idling
		gap_pct = 0;
		set_duplicates(1'b0);
		random_items(250, 45);

		set_duplicates(1'b1);
		random_items(60, 50);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tbl.pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, tbl.pending_results.size());
			tbl.failures++;
		end
		$display("checked %0d results: %0d inserts, %0d key deletes, %0d index deletes, %0d finds",
			tbl.checked, tbl.op_seen[OP_INSERT], tbl.op_seen[OP_DEL_KEY],
			tbl.op_seen[OP_DEL_IDX], tbl.op_seen[OP_FIND]);
		$display("%0d reads, %0d clears, %0d full rejects, %0d duplicate rejects, peak %0d entries",
			tbl.op_seen[OP_READ], tbl.op_seen[OP_CLEAR], tbl.full_hits, tbl.dup_hits, tbl.peak);
		if (tbl.failures == 0)
			$display("PASS sorted_key_value_table_top");
		else
			$display("FAIL sorted_key_value_table_top");
		$finish;
	end

endmodule
